// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the bank mapper.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define CBM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mapper assertion failed");

// Next-cycle implication, switched off while reset is held.
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mapper assertion failed");

`endif

// File: rtl/cbm_pkg.sv
// Types, register codes and decode constants of the cartridge bank mapper.
// Self-contained; used by cartridge_bank_mapper_irq.
`default_nettype none

package cbm_pkg;

  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_A12_CLOCK = 2'd1,
    REQ_CPU_TICK  = 2'd2
  } req_kind_t;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANK_MAX = 2'd1;

  localparam logic [15:0] ADDR_DECODE_MASK = 16'hF003;
  localparam logic [15:0] ADDR_PRG_LO      = 16'h8000;
  localparam logic [15:0] ADDR_MIRROR      = 16'h9000;
  localparam logic [15:0] ADDR_PRG_HI      = 16'hA000;
  localparam logic [15:0] ADDR_CHR_0       = 16'hB000;
  localparam logic [15:0] ADDR_CHR_1       = 16'hB002;
  localparam logic [15:0] ADDR_CHR_2       = 16'hC000;
  localparam logic [15:0] ADDR_CHR_3       = 16'hC002;
  localparam logic [15:0] ADDR_CHR_4       = 16'hD000;
  localparam logic [15:0] ADDR_CHR_5       = 16'hD002;
  localparam logic [15:0] ADDR_CHR_6       = 16'hE000;
  localparam logic [15:0] ADDR_CHR_7       = 16'hE002;
  localparam logic [15:0] ADDR_IRQ_COUNT   = 16'hF000;

  localparam logic [7:0] BANK_MAX_RESET  = 8'hFF;
  localparam logic [7:0] IRQ_WRAP_POINT  = 8'd240;
  localparam logic [4:0] IRQ_DELAY_START = 5'd16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] cpu_address;
    logic [7:0]  write_value;
  } cbm_req_t;

  typedef struct packed {
    logic [7:0] prg_bank_lo;
    logic [7:0] prg_bank_hi;
    logic [7:0] chr_bank_0;
    logic [7:0] chr_bank_1;
    logic [7:0] chr_bank_2;
    logic [7:0] chr_bank_3;
    logic [7:0] chr_bank_4;
    logic [7:0] chr_bank_5;
    logic [7:0] chr_bank_6;
    logic [7:0] chr_bank_7;
    logic       mirror_horizontal;
    logic       irq_pending;
  } cbm_res_t;

  // A bank number above the maximum is ANDed with the maximum.
  function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] maxv);
    return (v > maxv) ? (v & maxv) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cartridge_bank_mapper_irq.sv
// Top level of the cartridge bank mapper with scanline IRQ counter.
// Depends on cbm_pkg and on the assertion macros in assert_macros.svh.
`default_nettype none

// Usage:
// The in_ channel carries one request per handshake: a CPU write (address and
// byte), a PPU A12 rising-edge clock, or a CPU cycle tick. Every accepted
// request yields exactly one result on the out_ channel: a snapshot of the
// program banks, character banks, mirroring bit and IRQ line after the
// request has been applied.
// The result is registered: a request's result shows on out_data in the
// cycle after it is accepted. Throughput is one request per cycle while
// the receiver keeps up, set by the single state update between the input
// handshake and the result register. While the receiver stalls, the result
// register holds and in_ready is low; as soon as the result is taken, a new
// request is accepted in the same cycle.
// The cfg_ channel writes the two bank maximum registers and is always ready;
// indexes beyond the register list are ignored. Writes are expected only while
// the block is idle.
// A synchronous active-low reset clears all bank registers, the mirroring bit
// and the IRQ counter, delay and flag, sets both maximums to 255 and empties
// the result register.

module cartridge_bank_mapper_irq (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  cbm_pkg::cbm_req_t                in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output cbm_pkg::cbm_res_t                out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [7:0]                        cfg_data
);
  import cbm_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [7:0] prg_bank_max_r;
  logic [7:0] chr_bank_max_r;

  // Mapper state and its next values.
  logic [7:0] prg_bank_r [2];
  logic [7:0] chr_bank_r [8];
  logic       mirror_r;
  logic [7:0] irq_counter_r;
  logic [4:0] irq_delay_r;
  logic       irq_flag_r;

  logic [7:0] prg_bank_nxt [2];
  logic [7:0] chr_bank_nxt [8];
  logic       mirror_nxt;
  logic [7:0] irq_counter_nxt;
  logic [4:0] irq_delay_nxt;
  logic       irq_flag_nxt;

  // Result register.
  logic     out_valid_r;
  cbm_res_t out_data_r;
  cbm_res_t res_nxt;

  logic       in_accept;
  logic [7:0] counter_inc;
  logic [4:0] delay_dec;
  logic [7:0] prg_limited;
  logic [7:0] chr_limited;

  // A new request may enter whenever the result register is empty or being
  // drained in this same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign counter_inc = irq_counter_r + 8'd1;
  assign delay_dec   = irq_delay_r - 5'd1;
  assign prg_limited = limit_bank(in_data.write_value, prg_bank_max_r);
  assign chr_limited = limit_bank(in_data.write_value, chr_bank_max_r);

  // State update for one request.
  always_comb begin
    prg_bank_nxt    = prg_bank_r;
    chr_bank_nxt    = chr_bank_r;
    mirror_nxt      = mirror_r;
    irq_counter_nxt = irq_counter_r;
    irq_delay_nxt   = irq_delay_r;
    irq_flag_nxt    = irq_flag_r;

    case (in_data.req_type)
      REQ_CPU_WRITE: begin
        unique case (in_data.cpu_address & ADDR_DECODE_MASK)
          ADDR_PRG_LO: prg_bank_nxt[0] = prg_limited;
          ADDR_PRG_HI: prg_bank_nxt[1] = prg_limited;
          ADDR_MIRROR: mirror_nxt = in_data.write_value[0];
          ADDR_CHR_0:  chr_bank_nxt[0] = chr_limited;
          ADDR_CHR_1:  chr_bank_nxt[1] = chr_limited;
          ADDR_CHR_2:  chr_bank_nxt[2] = chr_limited;
          ADDR_CHR_3:  chr_bank_nxt[3] = chr_limited;
          ADDR_CHR_4:  chr_bank_nxt[4] = chr_limited;
          ADDR_CHR_5:  chr_bank_nxt[5] = chr_limited;
          ADDR_CHR_6:  chr_bank_nxt[6] = chr_limited;
          ADDR_CHR_7:  chr_bank_nxt[7] = chr_limited;
          ADDR_IRQ_COUNT: begin
            // Reloading the counter acknowledges the interrupt; the delay runs on.
            irq_counter_nxt = in_data.write_value;
            irq_flag_nxt    = 1'b0;
          end
          default: ;
        endcase
      end
      REQ_A12_CLOCK: begin
        // A stopped (zero) counter ignores A12. Reaching 240 or more clears it
        // and (re)arms the delay; the wrap from 255 lands on zero and stops.
        if (irq_counter_r != 8'd0) begin
          if (counter_inc >= IRQ_WRAP_POINT) begin
            irq_counter_nxt = 8'd0;
            irq_delay_nxt   = IRQ_DELAY_START;
          end else begin
            irq_counter_nxt = counter_inc;
          end
        end
      end
      REQ_CPU_TICK: begin
        if (irq_delay_r != 5'd0) begin
          irq_delay_nxt = delay_dec;
          if (delay_dec == 5'd0) begin
            irq_flag_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // The result is the state as it stands after the request.
  always_comb begin
    res_nxt.prg_bank_lo       = prg_bank_nxt[0];
    res_nxt.prg_bank_hi       = prg_bank_nxt[1];
    res_nxt.chr_bank_0        = chr_bank_nxt[0];
    res_nxt.chr_bank_1        = chr_bank_nxt[1];
    res_nxt.chr_bank_2        = chr_bank_nxt[2];
    res_nxt.chr_bank_3        = chr_bank_nxt[3];
    res_nxt.chr_bank_4        = chr_bank_nxt[4];
    res_nxt.chr_bank_5        = chr_bank_nxt[5];
    res_nxt.chr_bank_6        = chr_bank_nxt[6];
    res_nxt.chr_bank_7        = chr_bank_nxt[7];
    res_nxt.mirror_horizontal = mirror_nxt;
    res_nxt.irq_pending       = irq_flag_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_max_r <= BANK_MAX_RESET;
      chr_bank_max_r <= BANK_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRG_BANK_MAX: prg_bank_max_r <= cfg_data;
        CFG_CHR_BANK_MAX: chr_bank_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mapper state, committed only when a request is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r    <= '{default: 8'd0};
      chr_bank_r    <= '{default: 8'd0};
      mirror_r      <= 1'b0;
      irq_counter_r <= 8'd0;
      irq_delay_r   <= 5'd0;
      irq_flag_r    <= 1'b0;
    end else if (in_accept) begin
      prg_bank_r    <= prg_bank_nxt;
      chr_bank_r    <= chr_bank_nxt;
      mirror_r      <= mirror_nxt;
      irq_counter_r <= irq_counter_nxt;
      irq_delay_r   <= irq_delay_nxt;
      irq_flag_r    <= irq_flag_nxt;
    end
  end

  // Result register: loads on every accepted request, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res_nxt;
    end
  end

  // Every accepted request leaves a result waiting in the next cycle.
  `CBM_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
  // The delay is only ever armed with its start value and then counts down.
  `CBM_ASSERT_IMPL(a_delay_bounded, 1'b1, irq_delay_r <= IRQ_DELAY_START)
  // The IRQ flag rises only when the delay expires on a tick.
  `CBM_ASSERT_IMPL(a_irq_from_delay, $rose(irq_flag_r), $past(irq_delay_r) == 5'd1)

endmodule

`default_nettype wire

// File: verif/tb_cartridge_bank_mapper_irq.sv
// Self-checking testbench for the cartridge bank mapper with scanline IRQ counter.
// Needs cbm_pkg and the cartridge_bank_mapper_irq top level; predicts every
// snapshot in SystemVerilog and checks the results in order.
`default_nettype none

module tb_cartridge_bank_mapper_irq;
  import cbm_pkg::*;

  // Request type 3 has no meaning in the mapper and must leave all state alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // The config port is two bits wide but only two registers exist.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int MAX_REPORTS = 40;
  localparam int CHUNK_SIZE = 75;
  localparam int CHUNKS = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cbm_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cbm_res_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  cartridge_bank_mapper_irq dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and the snapshots the mapper owes us for
  // requests it has already accepted. The driver pops the first queue only at
  // the handshake, so its head is always the request currently on in_data.
  cbm_req_t request_q[$];
  cbm_res_t snapshot_q[$];

  // Percentages of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int failures = 0;
  int requests_sent = 0;
  int snapshots_checked = 0;
  int clipped_writes = 0;
  int irq_raises = 0;
  int settings_used = 0;

  // Shadow copy of the mapper: bank limits, bank registers, mirroring and the
  // scanline counter with its short delay before the IRQ line goes up.
  logic [7:0] prg_limit;
  logic [7:0] chr_limit;
  logic [7:0] prg_reg [2];
  logic [7:0] chr_reg [8];
  logic       mirror_reg;
  logic [7:0] scan_count;
  logic [4:0] irq_wait;
  logic       irq_line;

  // A bank number past the limit is ANDed with the limit; legal ones pass as is.
  function automatic logic [7:0] bank_within(input logic [7:0] bank, input logic [7:0] lim);
    if (bank > lim) begin
      clipped_writes++;
      return bank & lim;
    end
    return bank;
  endfunction

  // Applies one request to the shadow state and returns the snapshot after it.
  function automatic cbm_res_t apply_request(input cbm_req_t req);
    cbm_res_t snap;
    case (req.req_type)
      REQ_CPU_WRITE: begin
        case (req.cpu_address & ADDR_DECODE_MASK)
          ADDR_PRG_LO:    prg_reg[0] = bank_within(req.write_value, prg_limit);
          ADDR_PRG_HI:    prg_reg[1] = bank_within(req.write_value, prg_limit);
          ADDR_MIRROR:    mirror_reg = req.write_value[0];
          ADDR_CHR_0:     chr_reg[0] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_1:     chr_reg[1] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_2:     chr_reg[2] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_3:     chr_reg[3] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_4:     chr_reg[4] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_5:     chr_reg[5] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_6:     chr_reg[6] = bank_within(req.write_value, chr_limit);
          ADDR_CHR_7:     chr_reg[7] = bank_within(req.write_value, chr_limit);
          ADDR_IRQ_COUNT: begin
            // Reloading the counter drops the IRQ but leaves a running delay alone.
            scan_count = req.write_value;
            irq_line = 1'b0;
          end
          default: ;
        endcase
      end
      REQ_A12_CLOCK: begin
        // A zero counter is parked. The 8-bit increment wraps from 255 to 0,
        // which parks it too; anything landing at 240 or above arms the delay.
        if (scan_count != 8'd0) begin
          scan_count = scan_count + 8'd1;
          if (scan_count >= IRQ_WRAP_POINT) begin
            scan_count = 8'd0;
            irq_wait = IRQ_DELAY_START;
          end
        end
      end
      REQ_CPU_TICK: begin
        if (irq_wait != 5'd0) begin
          irq_wait = irq_wait - 5'd1;
          if (irq_wait == 5'd0) begin
            if (!irq_line) irq_raises++;
            irq_line = 1'b1;
          end
        end
      end
      default: ;
    endcase
    snap.prg_bank_lo = prg_reg[0];
    snap.prg_bank_hi = prg_reg[1];
    snap.chr_bank_0 = chr_reg[0];
    snap.chr_bank_1 = chr_reg[1];
    snap.chr_bank_2 = chr_reg[2];
    snap.chr_bank_3 = chr_reg[3];
    snap.chr_bank_4 = chr_reg[4];
    snap.chr_bank_5 = chr_reg[5];
    snap.chr_bank_6 = chr_reg[6];
    snap.chr_bank_7 = chr_reg[7];
    snap.mirror_horizontal = mirror_reg;
    snap.irq_pending = irq_line;
    return snap;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_snapshot(input cbm_res_t got);
    cbm_res_t want;
    if (snapshot_q.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: unexpected result, expected none, got %h", $time, got);
    end else begin
      want = snapshot_q.pop_front();
      snapshots_checked++;
      check_field("prg_bank_lo", want.prg_bank_lo, got.prg_bank_lo);
      check_field("prg_bank_hi", want.prg_bank_hi, got.prg_bank_hi);
      check_field("chr_bank_0", want.chr_bank_0, got.chr_bank_0);
      check_field("chr_bank_1", want.chr_bank_1, got.chr_bank_1);
      check_field("chr_bank_2", want.chr_bank_2, got.chr_bank_2);
      check_field("chr_bank_3", want.chr_bank_3, got.chr_bank_3);
      check_field("chr_bank_4", want.chr_bank_4, got.chr_bank_4);
      check_field("chr_bank_5", want.chr_bank_5, got.chr_bank_5);
      check_field("chr_bank_6", want.chr_bank_6, got.chr_bank_6);
      check_field("chr_bank_7", want.chr_bank_7, got.chr_bank_7);
      check_field("mirror_horizontal", {7'd0, want.mirror_horizontal},
                  {7'd0, got.mirror_horizontal});
      check_field("irq_pending", {7'd0, want.irq_pending}, {7'd0, got.irq_pending});
    end
  endtask

  // Request driver. The expected snapshot is computed at the handshake edge,
  // before the mapper can present the matching result. A request
  // that is still waiting for in_ready is held with its payload untouched.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        snapshot_q.push_back(apply_request(request_q.pop_front()));
        requests_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. out_ready is redrawn every cycle, so stalls land on any
  // phase of the counter and delay sequences.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_snapshot(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic cbm_req_t build_request(input logic [1:0] kind, input logic [15:0] addr,
                                             input logic [7:0] value);
    cbm_req_t r;
    r.req_type = kind;
    r.cpu_address = addr;
    r.write_value = value;
    return r;
  endfunction

  // One of the twelve decoded register addresses or unmapped E003, with the address
  // bits outside the decode mask filled at random since the mapper ignores them.
  function automatic logic [15:0] decoded_address();
    logic [15:0] base;
    case ($urandom_range(0, 12))
      0:  base = ADDR_PRG_LO;
      1:  base = ADDR_PRG_HI;
      2:  base = ADDR_MIRROR;
      3:  base = ADDR_CHR_0;
      4:  base = ADDR_CHR_1;
      5:  base = ADDR_CHR_2;
      6:  base = ADDR_CHR_3;
      7:  base = ADDR_CHR_4;
      8:  base = ADDR_CHR_5;
      9:  base = ADDR_CHR_6;
      10: base = ADDR_CHR_7;
      11: base = ADDR_IRQ_COUNT;
      default: base = ADDR_CHR_7 | 16'h0001;
    endcase
    return base | (16'($urandom) & ~ADDR_DECODE_MASK);
  endfunction

  // Mostly register writes and counter traffic; a few of the unused request type.
  // Address and data are random for every type, including the ones that
  // ignore them.
  function automatic cbm_req_t random_request();
    cbm_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = build_request(REQ_UNUSED, 16'($urandom), 8'($urandom));
    if (pick < 40) begin
      r.req_type = REQ_CPU_WRITE;
      if ($urandom_range(0, 99) < 75) r.cpu_address = decoded_address();
    end else if (pick < 65) begin
      r.req_type = REQ_A12_CLOCK;
    end else if (pick < 95) begin
      r.req_type = REQ_CPU_TICK;
    end
    return r;
  endfunction

  // A realistic scanline sequence: load the counter close to the wrap point,
  // then mix clocks on A12 with CPU ticks so the delay arms, gets rearmed and
  // runs out. Returns how many requests it queued.
  task automatic queue_irq_run(output int added);
    cbm_req_t r;
    int steps;
    int pick;
    r = build_request(REQ_CPU_WRITE, ADDR_IRQ_COUNT | (16'($urandom) & ~ADDR_DECODE_MASK),
                      8'($urandom_range(226, 255)));
    request_q.push_back(r);
    steps = $urandom_range(20, 45);
    for (int k = 0; k < steps; k++) begin
      pick = $urandom_range(0, 99);
      r = random_request();
      if (pick < 40) r.req_type = REQ_A12_CLOCK;
      else if (pick < 92) r.req_type = REQ_CPU_TICK;
      request_q.push_back(r);
    end
    added = steps + 1;
  endtask

  task automatic queue_traffic(input int count);
    int queued;
    int added;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_irq_run(added);
        queued += added;
      end else begin
        request_q.push_back(random_request());
        queued++;
      end
    end
  endtask

  // Config writes happen only with both queues empty. The shadow limits are
  // updated at the same edge as the mapper's registers.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PRG_BANK_MAX) prg_limit = value;
    else if (idx == CFG_CHR_BANK_MAX) chr_limit = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [7:0] prg_max, input logic [7:0] chr_max);
    write_limit(CFG_PRG_BANK_MAX, prg_max);
    write_limit(CFG_CHR_BANK_MAX, chr_max);
    settings_used++;
    @(negedge clk);
  endtask

  // Waits on the falling edge so the queue sizes are read away from the
  // edge at which the driver and monitor change them.
  task automatic drain();
    while (request_q.size() != 0 || snapshot_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    logic [7:0] prg_max;
    logic [7:0] chr_max;
    prg_limit = BANK_MAX_RESET;
    chr_limit = BANK_MAX_RESET;
    prg_reg[0] = 8'd0;
    prg_reg[1] = 8'd0;
    for (int i = 0; i < 8; i++) chr_reg[i] = 8'd0;
    mirror_reg = 1'b0;
    scan_count = 8'd0;
    irq_wait = 5'd0;
    irq_line = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: a write to the unused config index, widest limits, then
    // the reset snapshot, writes to several decoded registers, unmapped
    // addresses, the unused request type, a parked counter, the 8-bit wrap,
    // arming at and above the wrap point, and a rearm.
    send_idle_pct = 24;
    recv_idle_pct = 87;
    write_limit(CFG_UNUSED_IDX, 8'h00);
    set_limits(8'hFF, 8'hFF);
    request_q.push_back(build_request(REQ_CPU_TICK, 16'h0000, 8'h00));
    request_q.push_back(build_request(REQ_UNUSED, 16'hFFFF, 8'hFF));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_PRG_LO, 8'hFF));
    request_q.push_back(build_request(REQ_CPU_WRITE, 16'hAFFC, 8'h00));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_MIRROR, 8'h01));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_CHR_0, 8'h80));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_CHR_7, 8'h7F));
    request_q.push_back(build_request(REQ_CPU_WRITE, 16'hCFFE, 8'hFF));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_PRG_LO | 16'h0001, 8'hAA));
    request_q.push_back(build_request(REQ_CPU_WRITE, 16'h0000, 8'hFF));
    request_q.push_back(build_request(REQ_CPU_WRITE, 16'hFFFF, 8'h55));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_MIRROR, 8'hFE));
    request_q.push_back(build_request(REQ_A12_CLOCK, 16'h1234, 8'h5A));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_IRQ_COUNT, 8'hFF));
    request_q.push_back(build_request(REQ_A12_CLOCK, 16'hFFFF, 8'hFF));
    request_q.push_back(build_request(REQ_A12_CLOCK, 16'h0000, 8'h00));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_IRQ_COUNT, 8'hF5));
    request_q.push_back(build_request(REQ_A12_CLOCK, 16'hA5A5, 8'hA5));
    request_q.push_back(build_request(REQ_CPU_TICK, 16'h5A5A, 8'h5A));
    request_q.push_back(build_request(REQ_CPU_TICK, 16'hFFFF, 8'hFF));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_IRQ_COUNT, 8'hEF));
    request_q.push_back(build_request(REQ_A12_CLOCK, 16'h0F0F, 8'hF0));
    request_q.push_back(build_request(REQ_CPU_TICK, 16'h0000, 8'h00));
    request_q.push_back(build_request(REQ_CPU_TICK, 16'hFFFF, 8'hFF));
    request_q.push_back(build_request(REQ_CPU_WRITE, ADDR_IRQ_COUNT, 8'h00));
    drain();

    // Random part in chunks, each with its own bank limits. In the first pair of
    // chunks the receiver often stalls, in the second pair the sender often holds
    // back, and the last pair runs back to back.
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk)
        0: begin prg_max = 8'h1F; chr_max = 8'h7F; end
        1: begin prg_max = 8'h00; chr_max = 8'hFF; end
        2: begin prg_max = 8'($urandom); chr_max = 8'($urandom); end
        3: begin prg_max = 8'hFF; chr_max = 8'h00; end
        4: begin prg_max = 8'($urandom); chr_max = 8'($urandom); end
        default: begin prg_max = 8'h80; chr_max = 8'h01; end
      endcase
      if (chunk < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 87;
      end else if (chunk < 4) begin
        send_idle_pct = 87;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_limits(prg_max, chr_max);
      queue_traffic(CHUNK_SIZE);
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d mapper requests under %0d bank-limit settings; %0d results checked.",
             requests_sent, settings_used, snapshots_checked);
    $display("Bank writes clipped by a limit: %0d; IRQ line raised %0d times.",
             clipped_writes, irq_raises);
    if (failures == 0 && snapshot_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
